FILE: hw/rtl/ple_pkg.sv
// ---------------------------------------------------------------------------
// ple_pkg: shared types for the positional list engine
// Request and status codes, the item structs of both channels and the
// command that the control hands to the row of cells.
// ---------------------------------------------------------------------------
package ple_pkg;

    typedef enum logic [2:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_BACK  = 3'd1,
        REQ_INS_POS   = 3'd2,
        REQ_REM_FRONT = 3'd3,
        REQ_REM_BACK  = 3'd4,
        REQ_REM_POS   = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    localparam int unsigned POS_W   = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 7;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] item_value;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic               removed_valid;
        logic [VALUE_W-1:0] removed_item;
        logic [COUNT_W-1:0] entry_count;
    } t_out;

    // Row command: at most one of the two is set
    typedef struct packed {
        logic ins;
        logic rem;
    } t_row_op;

endpackage

FILE: hw/rtl/ple_cell.sv
// ---------------------------------------------------------------------------
// ple_cell: one slot of the list
// Holds one entry; on a row command it keeps it, loads the new item, or
// takes the value of its left or right neighbour.
// ---------------------------------------------------------------------------
module ple_cell #(
    parameter int unsigned IDX     = 0,
    parameter int unsigned CW      = 7,
    parameter int unsigned W       = 32
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  ple_pkg::t_row_op i_op,
    input  logic [CW-1:0]    i_at,
    input  logic [W-1:0]     i_item,
    input  logic [W-1:0]     i_left,
    input  logic [W-1:0]     i_right,
    output logic [W-1:0]     o_val,
    output logic [W-1:0]     o_hit
);

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [W-1:0] r_val;
    logic [W-1:0] n_val;

    always_comb begin
        n_val = r_val;
        if (i_en && i_op.ins) begin
            if (IDX_C > i_at) begin
                n_val = i_left;
            end else if (IDX_C == i_at) begin
                n_val = i_item;
            end
        end else if (i_en && i_op.rem) begin
            // close the gap: every slot from the removed one on takes its right neighbour
            if (IDX_C >= i_at) begin
                n_val = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_hit = (i_op.rem && IDX_C == i_at) ? r_val : '0;

endmodule

FILE: hw/rtl/ple_ctrl.sv
// ---------------------------------------------------------------------------
// ple_ctrl: request decode and entry count
// Checks a request against the count, picks the target slot and the row
// command, and updates the count when an item is taken.
// ---------------------------------------------------------------------------
module ple_ctrl #(
    parameter int unsigned CAPACITY = 64,
    parameter int unsigned CW       = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  ple_pkg::t_in     i_req,
    output ple_pkg::t_row_op o_op,
    output logic [CW-1:0]    o_at,
    output logic [1:0]       o_status,
    output logic [CW-1:0]    o_count_next
);

    localparam int unsigned AW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [CW-1:0] r_count;
    logic [AW-1:0] pos_ext;
    logic [AW-1:0] cnt_ext;
    logic          full;
    logic          empty;

    assign pos_ext = AW'(i_req.position);
    assign cnt_ext = AW'(r_count);
    assign full    = (r_count >= CAP_C);
    assign empty   = (r_count == '0);

    always_comb begin
        o_op         = '0;
        o_at         = '0;
        o_status     = ple_pkg::ST_OK;
        o_count_next = r_count;
        unique case (i_req.req_type)
            ple_pkg::REQ_INS_FRONT, ple_pkg::REQ_INS_BACK, ple_pkg::REQ_INS_POS: begin
                if (i_req.req_type == ple_pkg::REQ_INS_BACK) begin
                    o_at = r_count;
                end else if (i_req.req_type == ple_pkg::REQ_INS_POS) begin
                    o_at = pos_ext[CW-1:0];
                end
                if (i_req.req_type == ple_pkg::REQ_INS_POS && pos_ext > cnt_ext) begin
                    o_status = ple_pkg::ST_BADPOS;
                end else if (full) begin
                    o_status = ple_pkg::ST_FULL;
                end else begin
                    o_op.ins     = 1'b1;
                    o_count_next = r_count + 1'b1;
                end
            end
            ple_pkg::REQ_REM_FRONT, ple_pkg::REQ_REM_BACK: begin
                if (i_req.req_type == ple_pkg::REQ_REM_BACK) begin
                    o_at = r_count - 1'b1;
                end
                if (empty) begin
                    o_status = ple_pkg::ST_EMPTY;
                end else begin
                    o_op.rem     = 1'b1;
                    o_count_next = r_count - 1'b1;
                end
            end
            ple_pkg::REQ_REM_POS: begin
                o_at = pos_ext[CW-1:0];
                if (pos_ext >= cnt_ext) begin
                    o_status = ple_pkg::ST_BADPOS;
                end else begin
                    o_op.rem     = 1'b1;
                    o_count_next = r_count - 1'b1;
                end
            end
            default: begin
                // unused codes: drop, list unchanged
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_take) begin
            r_count <= o_count_next;
        end
    end

endmodule

FILE: hw/rtl/positional_list_engine_top.sv
// ---------------------------------------------------------------------------
// positional_list_engine_top: ordered list of item handles
// Insert and remove at front, back or a given position, with status.
// ---------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, and every cell behind the
// target slot takes its neighbour's entry in the same clock edge that
// accepts the item, so a new item can be accepted every cycle while the
// output register is free or being emptied. The result (status, removed
// handle, count after the request) sits in one output register; the
// removed handle is gathered from the row by an OR of the cells' outputs,
// which sets the longest path together with the position compare in each
// cell.
module positional_list_engine_top #(
    parameter int unsigned CAPACITY   = 64,
    parameter int unsigned ITEM_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ple_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ple_pkg::t_out o_out
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned W  = ITEM_WIDTH;

    logic             take;
    ple_pkg::t_row_op op;
    logic [CW-1:0]    at;
    logic [1:0]       status;
    logic [CW-1:0]    count_next;
    logic [63:0]      item_wide;
    logic [W-1:0]     item;
    logic [W-1:0]     w_val [CAPACITY];
    logic [W-1:0]     w_hit [CAPACITY];
    logic [W-1:0]     removed;
    logic [63:0]      removed_wide;
    logic [31:0]      count_wide;

    logic             r_out_valid;
    ple_pkg::t_out    r_out;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign take       = i_in_valid && o_in_ready;

    assign item_wide = 64'(i_in.item_value);
    assign item      = item_wide[W-1:0];

    ple_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_req        (i_in),
        .o_op         (op),
        .o_at         (at),
        .o_status     (status),
        .o_count_next (count_next)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [W-1:0] left;
        logic [W-1:0] right;
        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid_l
            assign left = w_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid_r
            assign right = w_val[g+1];
        end
        ple_cell #(
            .IDX (g),
            .CW  (CW),
            .W   (W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_en    (take),
            .i_op    (op),
            .i_at    (at),
            .i_item  (item),
            .i_left  (left),
            .i_right (right),
            .o_val   (w_val[g]),
            .o_hit   (w_hit[g])
        );
    end

    always_comb begin
        removed = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            removed = removed | w_hit[k];
        end
    end

    assign removed_wide = 64'(removed);
    assign count_wide   = 32'(count_next);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out.status        <= status;
            r_out.removed_valid <= op.rem;
            r_out.removed_item  <= removed_wide[31:0];
            r_out.entry_count   <= count_wide[6:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: hw/rtl/ple_chk.sv
// ---------------------------------------------------------------------------
// ple_chk: port checks for the positional list engine
// Result consistency and output hold under stall, bound to the top level.
// ---------------------------------------------------------------------------
module ple_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input ple_pkg::t_out o_out
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    a_removed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.removed_valid |-> o_out.status == ple_pkg::ST_OK)
        else $error("removal reported with bad status");

    a_removed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.removed_valid |-> o_out.removed_item == '0)
        else $error("removed item not zero without removal");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ple_pkg::ST_EMPTY |-> o_out.entry_count == '0)
        else $error("empty status with entries left");

endmodule

bind positional_list_engine_top ple_chk u_ple_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
